// ----- design/dmp_pkg.sv -----
// ----------------------------------------------------------------------------
// dmp_pkg
// Shared types and constants for the DNS message parser.
// ----------------------------------------------------------------------------
`default_nettype none

package dmp_pkg;

    // Longest name on the wire, final zero byte included.
    localparam int unsigned MAX_NAME_BYTES = 255;

    localparam logic [7:0] CHAR_DOT = 8'h2E;

    // Walker phases
    localparam logic [3:0] PH_HEADER = 4'd0;
    localparam logic [3:0] PH_QNAME  = 4'd1;
    localparam logic [3:0] PH_QFIX   = 4'd2;
    localparam logic [3:0] PH_ANAME  = 4'd3;
    localparam logic [3:0] PH_AFIX   = 4'd4;
    localparam logic [3:0] PH_RDATA  = 4'd5;
    localparam logic [3:0] PH_DONE   = 4'd6;
    localparam logic [3:0] PH_ERROR  = 4'd7;

    // Last byte index per group; AFIX_ACC_BYTES is a byte count
    localparam logic [3:0] HDR_LAST_IDX   = 4'd11;
    localparam logic [3:0] QFIX_LAST_IDX  = 4'd3;
    localparam logic [3:0] AFIX_ACC_BYTES = 4'd8;
    localparam logic [3:0] AFIX_LAST_IDX  = 4'd9;

    // Result kinds
    localparam logic [2:0] KIND_HEADER    = 3'd0;
    localparam logic [2:0] KIND_NAME_CHAR = 3'd1;
    localparam logic [2:0] KIND_QUESTION  = 3'd2;
    localparam logic [2:0] KIND_ANSWER    = 3'd3;
    localparam logic [2:0] KIND_END       = 3'd4;
    localparam logic [2:0] KIND_SHORT_HDR = 3'd5;
    localparam logic [2:0] KIND_BAD_NAME  = 3'd6;
    localparam logic [2:0] KIND_TRUNCATED = 3'd7;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] msg_id;
        logic [15:0] msg_flags;
        logic [15:0] question_total;
        logic [15:0] answer_total;
        logic [15:0] authority_total;
        logic [15:0] additional_total;
        logic [7:0]  name_char;
        logic [15:0] rec_type;
        logic [15:0] rec_class;
        logic [31:0] time_to_live;
        logic        final_result;
    } t_result;

endpackage

`default_nettype wire

// ----- design/dmp_walker.sv -----
// ----------------------------------------------------------------------------
// dmp_walker
// Parse state and per-byte next-state/result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module dmp_walker (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_step,
    input  wire  [7:0]           i_byte,
    input  wire                  i_last,
    output logic                 o_res_valid,
    output dmp_pkg::t_result     o_res
);

    logic [3:0]  r_phase, n_phase;
    logic [3:0]  r_idx, n_idx;
    logic [95:0] r_hdr, n_hdr;
    logic [15:0] r_q, n_q;
    logic [15:0] r_a, n_a;
    logic [7:0]  r_nlu, n_nlu;
    logic [5:0]  r_label, n_label;
    logic        r_first, n_first;
    logic [63:0] r_acc, n_acc;
    logic [15:0] r_rdata, n_rdata;

    logic        has;
    logic [2:0]  kind;
    logic [7:0]  ch;
    logic        ans_done;
    logic [8:0]  used;

    always_comb begin
        n_phase  = r_phase;
        n_idx    = r_idx;
        n_hdr    = r_hdr;
        n_q      = r_q;
        n_a      = r_a;
        n_nlu    = r_nlu;
        n_label  = r_label;
        n_first  = r_first;
        n_acc    = r_acc;
        n_rdata  = r_rdata;
        has      = 1'b0;
        kind     = dmp_pkg::KIND_END;
        ch       = 8'd0;
        ans_done = 1'b0;
        used     = {1'b0, r_nlu} + 9'd1 + {1'b0, i_byte};

        case (r_phase)
            dmp_pkg::PH_HEADER: begin
                n_hdr = {r_hdr[87:0], i_byte};
                n_idx = r_idx + 4'd1;
                if (r_idx == dmp_pkg::HDR_LAST_IDX) begin
                    n_idx = 4'd0;
                    n_q   = n_hdr[63:48];
                    n_a   = n_hdr[47:32];
                    has   = 1'b1;
                    kind  = dmp_pkg::KIND_HEADER;
                    if (n_q != 16'd0) begin
                        n_phase = dmp_pkg::PH_QNAME;
                        n_nlu   = 8'd0;
                        n_label = 6'd0;
                        n_first = 1'b1;
                    end else if (n_a != 16'd0) begin
                        n_phase = dmp_pkg::PH_ANAME;
                        n_nlu   = 8'd0;
                        n_label = 6'd0;
                        n_first = 1'b1;
                    end else begin
                        n_phase = dmp_pkg::PH_DONE;
                    end
                end
            end
            dmp_pkg::PH_QNAME, dmp_pkg::PH_ANAME: begin
                if (r_label != 6'd0) begin
                    n_label = r_label - 6'd1;
                    ch      = i_byte;
                    has     = 1'b1;
                    kind    = dmp_pkg::KIND_NAME_CHAR;
                end else if (i_byte == 8'd0) begin
                    n_phase = (r_phase == dmp_pkg::PH_QNAME) ? dmp_pkg::PH_QFIX
                                                             : dmp_pkg::PH_AFIX;
                    n_idx   = 4'd0;
                end else if (i_byte[7:6] != 2'b00) begin
                    // compression pointer or reserved label type
                    n_phase = dmp_pkg::PH_ERROR;
                    has     = 1'b1;
                    kind    = dmp_pkg::KIND_BAD_NAME;
                end else if (used >= 9'(dmp_pkg::MAX_NAME_BYTES)) begin
                    n_phase = dmp_pkg::PH_ERROR;
                    has     = 1'b1;
                    kind    = dmp_pkg::KIND_BAD_NAME;
                end else begin
                    n_nlu   = used[7:0];
                    n_label = i_byte[5:0];
                    if (r_first) begin
                        n_first = 1'b0;
                    end else begin
                        ch   = dmp_pkg::CHAR_DOT;
                        has  = 1'b1;
                        kind = dmp_pkg::KIND_NAME_CHAR;
                    end
                end
            end
            dmp_pkg::PH_QFIX: begin
                n_acc = {r_acc[55:0], i_byte};
                n_idx = r_idx + 4'd1;
                if (r_idx == dmp_pkg::QFIX_LAST_IDX) begin
                    n_idx = 4'd0;
                    has   = 1'b1;
                    kind  = dmp_pkg::KIND_QUESTION;
                    n_q   = r_q - 16'd1;
                    if (n_q != 16'd0) begin
                        n_phase = dmp_pkg::PH_QNAME;
                        n_nlu   = 8'd0;
                        n_label = 6'd0;
                        n_first = 1'b1;
                    end else if (r_a != 16'd0) begin
                        n_phase = dmp_pkg::PH_ANAME;
                        n_nlu   = 8'd0;
                        n_label = 6'd0;
                        n_first = 1'b1;
                    end else begin
                        n_phase = dmp_pkg::PH_DONE;
                    end
                end
            end
            dmp_pkg::PH_AFIX: begin
                if (r_idx < dmp_pkg::AFIX_ACC_BYTES) begin
                    n_acc = {r_acc[55:0], i_byte};
                end else begin
                    n_rdata = {r_rdata[7:0], i_byte};
                end
                n_idx = r_idx + 4'd1;
                if (r_idx == dmp_pkg::AFIX_LAST_IDX) begin
                    n_idx = 4'd0;
                    if (n_rdata == 16'd0) begin
                        ans_done = 1'b1;
                    end else begin
                        n_phase = dmp_pkg::PH_RDATA;
                    end
                end
            end
            dmp_pkg::PH_RDATA: begin
                n_rdata = r_rdata - 16'd1;
                if (n_rdata == 16'd0) begin
                    ans_done = 1'b1;
                end
            end
            default: begin
            end
        endcase

        if (ans_done) begin
            has  = 1'b1;
            kind = dmp_pkg::KIND_ANSWER;
            n_a  = r_a - 16'd1;
            if (n_a != 16'd0) begin
                n_phase = dmp_pkg::PH_ANAME;
                n_nlu   = 8'd0;
                n_label = 6'd0;
                n_first = 1'b1;
            end else begin
                n_phase = dmp_pkg::PH_DONE;
            end
        end

        // end-of-message byte: settle the closing kind, then back to reset state
        if (i_last) begin
            if (has && kind == dmp_pkg::KIND_BAD_NAME) begin
                has = 1'b1;
            end else if (r_phase == dmp_pkg::PH_ERROR) begin
                has  = 1'b1;
                kind = dmp_pkg::KIND_END;
            end else if (n_phase == dmp_pkg::PH_DONE) begin
                if (!has) begin
                    has  = 1'b1;
                    kind = dmp_pkg::KIND_END;
                end
            end else if (n_phase == dmp_pkg::PH_HEADER) begin
                has  = 1'b1;
                kind = dmp_pkg::KIND_SHORT_HDR;
            end else begin
                has  = 1'b1;
                kind = dmp_pkg::KIND_TRUNCATED;
            end
            n_phase = dmp_pkg::PH_HEADER;
            n_idx   = 4'd0;
            n_q     = 16'd0;
            n_a     = 16'd0;
            n_nlu   = 8'd0;
            n_label = 6'd0;
            n_first = 1'b1;
            n_rdata = 16'd0;
        end
    end

    always_comb begin
        o_res_valid        = has;
        o_res              = '0;
        o_res.kind         = kind;
        o_res.final_result = i_last;
        if (kind == dmp_pkg::KIND_HEADER) begin
            o_res.msg_id           = n_hdr[95:80];
            o_res.msg_flags        = n_hdr[79:64];
            o_res.question_total   = n_hdr[63:48];
            o_res.answer_total     = n_hdr[47:32];
            o_res.authority_total  = n_hdr[31:16];
            o_res.additional_total = n_hdr[15:0];
        end
        if (kind == dmp_pkg::KIND_NAME_CHAR) begin
            o_res.name_char = ch;
        end
        if (kind == dmp_pkg::KIND_QUESTION) begin
            o_res.rec_type  = n_acc[31:16];
            o_res.rec_class = n_acc[15:0];
        end
        if (kind == dmp_pkg::KIND_ANSWER) begin
            o_res.rec_type     = n_acc[63:48];
            o_res.rec_class    = n_acc[47:32];
            o_res.time_to_live = n_acc[31:0];
        end
    end

    // field shift registers are fully refilled before use: no reset needed
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_hdr <= n_hdr;
            r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= dmp_pkg::PH_HEADER;
            r_idx   <= 4'd0;
            r_q     <= 16'd0;
            r_a     <= 16'd0;
            r_nlu   <= 8'd0;
            r_label <= 6'd0;
            r_first <= 1'b1;
            r_rdata <= 16'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_idx   <= n_idx;
            r_q     <= n_q;
            r_a     <= n_a;
            r_nlu   <= n_nlu;
            r_label <= n_label;
            r_first <= n_first;
            r_rdata <= n_rdata;
        end
    end

endmodule

`default_nettype wire

// ----- design/dmp_out_reg.sv -----
// ----------------------------------------------------------------------------
// dmp_out_reg
// Result holding register on the master side.
// ----------------------------------------------------------------------------
`default_nettype none

module dmp_out_reg (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_load,
    input  wire dmp_pkg::t_result i_res,
    input  wire                  i_ready,
    output logic                 o_valid,
    output logic                 o_free,
    output dmp_pkg::t_result     o_res
);

    logic             r_valid;
    dmp_pkg::t_result r_res;

    // free when empty or being drained this cycle
    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// ----- design/dns_message_parser.sv -----
// ----------------------------------------------------------------------------
// dns_message_parser
// Byte-serial DNS/mDNS message header, question and answer walker.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel takes one datagram byte per item (s_axis_tdata), with
//   s_axis_tlast on the final byte. Master channel emits zero or one result
//   item per byte: m_axis_tuser carries the kind, m_axis_tdata the header
//   words, name character, type/class and TTL, m_axis_tlast marks the result
//   caused by the final byte (every datagram yields exactly one such item).
//   Path: a taken byte is held in the input register; its result, if any,
//   is loaded into the result register when the walker steps on that byte,
//   which waits while the result register is full and not being drained.
//   Throughput: one byte per cycle while the result register is empty or
//   m_axis_tready is high; the walker state updates between the input and result registers.
//   Reset: synchronous, active low; parser returns to the header phase and
//   both registers empty. The parser also self-resets after every last byte.
//   Stall: while the result register is full and m_axis_tready is low, the
//   held byte waits in the input register; s_axis_tready drops only when
//   both are occupied, so nothing is lost or repeated.
//   Authority/additional sections and RDATA contents are skipped; compressed
//   names, overlong names and early ends are reported as error kinds.
// ----------------------------------------------------------------------------
`default_nettype none

module dns_message_parser (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    input  wire  [7:0]   s_axis_tdata,   // [7:0] message_byte
    input  wire          s_axis_tlast,   // end_of_message
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // [15:0] msg_id, [31:16] msg_flags, [47:32] question_total,
    // [63:48] answer_total, [79:64] authority_total, [95:80] additional_total,
    // [103:96] name_char, [119:104] rec_type, [135:120] rec_class,
    // [167:136] time_to_live
    output logic [167:0] m_axis_tdata,
    output logic [2:0]   m_axis_tuser,   // [2:0] kind
    output logic         m_axis_tlast    // final_result
);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    logic             step;
    logic             out_free;
    logic             res_valid;
    dmp_pkg::t_result res;
    dmp_pkg::t_result out_res;

    // the held byte is consumed whenever the result register can take its result
    assign step          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
    end

    dmp_walker u_walker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_byte      (r_in_byte),
        .i_last      (r_in_last),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    dmp_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step && res_valid),
        .i_res   (res),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_free  (out_free),
        .o_res   (out_res)
    );

    assign m_axis_tdata = {out_res.time_to_live, out_res.rec_class, out_res.rec_type,
                           out_res.name_char, out_res.additional_total,
                           out_res.authority_total, out_res.answer_total,
                           out_res.question_total, out_res.msg_flags, out_res.msg_id};
    assign m_axis_tuser = out_res.kind;
    assign m_axis_tlast = out_res.final_result;

endmodule

`default_nettype wire
